FILE: rtl/mvm_pkg.sv
package mvm_pkg;

	// Defaults for the top-level parameters
	localparam int MAX_ROWS_DEF   = 64;
	localparam int MAX_COLS_DEF   = 64;
	localparam int DATA_WIDTH_DEF = 16;

	// Fixed field widths
	localparam int IDX_W   = 6;
	localparam int PADDR_W = 5;

	// Item operation codes
	localparam logic [1:0] OP_LOAD_A = 2'd0;
	localparam logic [1:0] OP_LOAD_X = 2'd1;
	localparam logic [1:0] OP_LOAD_Y = 2'd2;
	localparam logic [1:0] OP_START  = 2'd3;

	// Register indexes (byte address / 4)
	localparam logic [2:0] REG_ROWS  = 3'd0;
	localparam logic [2:0] REG_COLS  = 3'd1;
	localparam logic [2:0] REG_ALPHA = 3'd2;
	localparam logic [2:0] REG_ADD   = 3'd3;
	localparam logic [2:0] REG_FRAC  = 3'd4;

	typedef struct packed {
		logic [6:0]         rows;
		logic [6:0]         cols;
		logic signed [15:0] alpha;
		logic               add_mode;
		logic [3:0]         frac;
	} cfg_t;

	localparam cfg_t CFG_RESET = '{
		rows:     7'd64,
		cols:     7'd64,
		alpha:    16'sd256,
		add_mode: 1'b0,
		frac:     4'd8
	};

	// Position of one multiply-accumulate step within a run
	typedef struct packed {
		logic [IDX_W-1:0] row;
		logic             first_col;
		logic             last_col;
		logic             last_row;
	} tag_t;

	// Side information that goes with each result
	typedef struct packed {
		logic [IDX_W-1:0] row;
		logic             last_of_run;
		logic             saturated;
	} res_info_t;

endpackage

FILE: rtl/mvm_intf.sv
interface mvm_cmd_if #(parameter int DATA_WIDTH = mvm_pkg::DATA_WIDTH_DEF);
	import mvm_pkg::*;

	logic                         valid;
	logic                         ready;
	logic [1:0]                   op;
	logic [IDX_W-1:0]             row_index;
	logic [IDX_W-1:0]             col_index;
	logic signed [DATA_WIDTH-1:0] element_value;

	modport source (output valid, op, row_index, col_index, element_value, input ready);
	modport sink (input valid, op, row_index, col_index, element_value, output ready);
endinterface

interface mvm_rsp_if #(parameter int DATA_WIDTH = mvm_pkg::DATA_WIDTH_DEF);
	import mvm_pkg::*;

	logic                         valid;
	logic                         ready;
	logic signed [DATA_WIDTH-1:0] result_value;
	logic [IDX_W-1:0]             result_row;
	logic                         last_of_run;
	logic                         saturated;

	modport source (output valid, result_value, result_row, last_of_run, saturated,
		input ready);
	modport sink (input valid, result_value, result_row, last_of_run, saturated,
		output ready);
endinterface

FILE: rtl/mvm_regs.sv
module mvm_regs (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [mvm_pkg::PADDR_W-1:0] paddr,
	input  logic [31:0]                 pwdata,
	output logic [31:0]                 prdata,
	output logic                        pready,
	output mvm_pkg::cfg_t               cfg
);
	import mvm_pkg::*;

	logic [2:0] idx;
	logic       wr;
	cfg_t       cfg_q;

	assign idx    = paddr[PADDR_W-1:2];
	assign wr     = psel && penable && pwrite;
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	// Register writes, masked to each field
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= CFG_RESET;
		end else if (wr) begin
			unique case (idx)
				REG_ROWS:  cfg_q.rows     <= pwdata[6:0];
				REG_COLS:  cfg_q.cols     <= pwdata[6:0];
				REG_ALPHA: cfg_q.alpha    <= signed'(pwdata[15:0]);
				REG_ADD:   cfg_q.add_mode <= pwdata[0];
				REG_FRAC:  cfg_q.frac     <= pwdata[3:0];
				default:   ;
			endcase
		end
	end

	// Read back
	always_comb begin
		unique case (idx)
			REG_ROWS:  prdata = {25'd0, cfg_q.rows};
			REG_COLS:  prdata = {25'd0, cfg_q.cols};
			REG_ALPHA: prdata = {16'd0, cfg_q.alpha};
			REG_ADD:   prdata = {31'd0, cfg_q.add_mode};
			REG_FRAC:  prdata = {28'd0, cfg_q.frac};
			default:   prdata = 32'd0;
		endcase
	end

endmodule

FILE: rtl/mvm_store.sv
module mvm_store #(
	parameter int MAX_ROWS   = mvm_pkg::MAX_ROWS_DEF,
	parameter int MAX_COLS   = mvm_pkg::MAX_COLS_DEF,
	parameter int DATA_WIDTH = mvm_pkg::DATA_WIDTH_DEF,
	localparam int RW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1,
	localparam int CW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1
) (
	input  logic                         clk,
	// load side
	input  logic                         wr_en,
	input  logic [1:0]                   wr_op,
	input  logic [mvm_pkg::IDX_W-1:0]    wr_row,
	input  logic [mvm_pkg::IDX_W-1:0]    wr_col,
	input  logic signed [DATA_WIDTH-1:0] wr_data,
	// run side
	input  logic                         rd_en,
	input  logic [RW-1:0]                rd_row,
	input  logic [CW-1:0]                rd_col,
	output logic signed [DATA_WIDTH-1:0] a_rd,
	output logic signed [DATA_WIDTH-1:0] x_rd,
	output logic signed [DATA_WIDTH-1:0] y_rd
);
	import mvm_pkg::*;

	localparam int MAT_DEPTH = MAX_ROWS * MAX_COLS;
	localparam int AW = (MAT_DEPTH > 1) ? $clog2(MAT_DEPTH) : 1;
	localparam int VW = (RW > CW) ? RW : CW;
	localparam int VEC_DEPTH = 2 * (2 ** VW);

	// Matrix in one memory, x in the lower half and y in the upper half of another
	logic signed [DATA_WIDTH-1:0] mat_mem [MAT_DEPTH];
	logic signed [DATA_WIDTH-1:0] vec_mem [VEC_DEPTH];

	logic                         mat_we;
	logic                         vec_we;
	logic [AW-1:0]                mat_wa;
	logic [AW-1:0]                mat_ra;
	logic [VW:0]                  vec_wa;
	logic                         row_ok;
	logic                         col_ok;
	logic signed [DATA_WIDTH-1:0] a_q;
	logic signed [DATA_WIDTH-1:0] x_q;
	logic signed [DATA_WIDTH-1:0] y_q;

	// Load decode; out-of-range indexes are dropped
	always_comb begin
		row_ok = int'(wr_row) < MAX_ROWS;
		col_ok = int'(wr_col) < MAX_COLS;
		mat_we = wr_en && (wr_op == OP_LOAD_A) && row_ok && col_ok;
		vec_we = wr_en && (((wr_op == OP_LOAD_X) && col_ok) ||
			((wr_op == OP_LOAD_Y) && row_ok));
		mat_wa = AW'(int'(wr_row) * MAX_COLS + int'(wr_col));
		vec_wa = (wr_op == OP_LOAD_Y) ? {1'b1, VW'(wr_row)} : {1'b0, VW'(wr_col)};
		mat_ra = AW'(int'(rd_row) * MAX_COLS + int'(rd_col));
	end

	// Write ports
	always_ff @(posedge clk) begin
		if (mat_we) begin
			mat_mem[mat_wa] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (vec_we) begin
			vec_mem[vec_wa] <= wr_data;
		end
	end

	// Registered reads, frozen while the pipeline stalls
	always_ff @(posedge clk) begin
		if (rd_en) begin
			a_q <= mat_mem[mat_ra];
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			x_q <= vec_mem[{1'b0, VW'(rd_col)}];
			y_q <= vec_mem[{1'b1, VW'(rd_row)}];
		end
	end

	assign a_rd = a_q;
	assign x_rd = x_q;
	assign y_rd = y_q;

endmodule

FILE: rtl/mvm_scale.sv
module mvm_scale #(
	parameter int DATA_WIDTH = mvm_pkg::DATA_WIDTH_DEF,
	parameter int ACC_W      = 2 * mvm_pkg::DATA_WIDTH_DEF + 6
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         en,
	input  mvm_pkg::cfg_t                cfg,
	input  logic                         v_in,
	input  logic signed [ACC_W-1:0]      dot,
	input  logic signed [DATA_WIDTH-1:0] y_in,
	input  mvm_pkg::tag_t                tag_in,
	output logic                         vld,
	output logic signed [DATA_WIDTH-1:0] value,
	output mvm_pkg::res_info_t           info
);
	import mvm_pkg::*;

	// Clamped shifted dot product: +-2^(DW+15) already forces saturation
	localparam int D_W = DATA_WIDTH + 17;
	localparam int P_W = D_W + 16;
	localparam int WC  = (ACC_W > D_W) ? ACC_W : D_W;
	localparam int SW  = P_W + 1;
	localparam logic signed [WC-1:0] LIM  = WC'(1) <<< (DATA_WIDTH + 15);
	localparam logic signed [WC-1:0] NLIM = -LIM;
	localparam logic signed [SW-1:0] HI   = (SW'(1) <<< (DATA_WIDTH - 1)) - SW'(1);
	localparam logic signed [SW-1:0] LO   = -HI - SW'(1);

	logic signed [ACC_W-1:0]      dsh;
	logic signed [WC-1:0]         dwide;
	logic signed [D_W-1:0]        dclamp;
	logic signed [P_W-1:0]        psh;
	logic signed [DATA_WIDTH-1:0] yadd;
	logic signed [SW-1:0]         sum;
	logic signed [DATA_WIDTH-1:0] res;
	logic                         sat;

	logic                         v_s4;
	logic signed [D_W-1:0]        d_s4;
	logic signed [DATA_WIDTH-1:0] y_s4;
	tag_t                         tag_s4;
	logic                         v_s5;
	logic signed [P_W-1:0]        p_s5;
	logic signed [DATA_WIDTH-1:0] y_s5;
	tag_t                         tag_s5;
	logic                         vld_q;
	logic signed [DATA_WIDTH-1:0] value_q;
	res_info_t                    info_q;

	// First rescale and clamp
	always_comb begin
		dsh   = dot >>> cfg.frac;
		dwide = WC'(dsh);
		if (dwide > LIM) begin
			dclamp = D_W'(LIM);
		end else if (dwide < NLIM) begin
			dclamp = D_W'(NLIM);
		end else begin
			dclamp = D_W'(dwide);
		end
	end

	// Second rescale, optional add of stored y, saturation
	always_comb begin
		psh  = p_s5 >>> cfg.frac;
		yadd = cfg.add_mode ? y_s5 : '0;
		sum  = SW'(psh) + SW'(yadd);
		if (sum > HI) begin
			res = DATA_WIDTH'(HI);
			sat = 1'b1;
		end else if (sum < LO) begin
			res = DATA_WIDTH'(LO);
			sat = 1'b1;
		end else begin
			res = DATA_WIDTH'(sum);
			sat = 1'b0;
		end
	end

	// Valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4  <= 1'b0;
			v_s5  <= 1'b0;
			vld_q <= 1'b0;
		end else if (en) begin
			v_s4  <= v_in;
			v_s5  <= v_s4;
			vld_q <= v_s5;
		end
	end

	// Payload stages: clamp, alpha multiply, output register
	always_ff @(posedge clk) begin
		if (en) begin
			d_s4    <= dclamp;
			y_s4    <= y_in;
			tag_s4  <= tag_in;
			p_s5    <= d_s4 * cfg.alpha;
			y_s5    <= y_s4;
			tag_s5  <= tag_s4;
			value_q <= res;
			info_q  <= '{row: tag_s5.row, last_of_run: tag_s5.last_row, saturated: sat};
		end
	end

	assign vld   = vld_q;
	assign value = value_q;
	assign info  = info_q;

endmodule

FILE: rtl/matrix_vector_multiply.sv
// Fixed point matrix-vector multiply, y = alpha*A*x or y += alpha*A*x.
// cmd channel (valid/ready): op 0/1/2 writes one element of A, x or stored y,
// one item per cycle while no run is active, no result. op 3 starts a run
// over the configured rows and columns and yields one result item per row on
// the rsp channel, rows in order, last_of_run set on the final one.
// APB port: registers rows_in_use, cols_in_use, alpha, add_mode, frac_bits at
// byte addresses 0, 4, 8, 12, 16; write them only while the block is idle.
// A run walks the matrix memory one element per cycle while rsp is not
// stalled: one multiply and one accumulate per cycle, so a start item holds
// cmd.ready low until the last element is read. The next item is taken right
// after the last element is read, while earlier rows still drain.
// A stall on rsp freezes the whole pipeline, memory reads included, so
// nothing is lost; results resume at full rate once rsp.ready returns.
// Reset clears control state and sets the registers to their defaults; the
// memories are not cleared and must be loaded before use.
module matrix_vector_multiply #(
	parameter int MAX_ROWS   = mvm_pkg::MAX_ROWS_DEF,
	parameter int MAX_COLS   = mvm_pkg::MAX_COLS_DEF,
	parameter int DATA_WIDTH = mvm_pkg::DATA_WIDTH_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	mvm_cmd_if.sink                     cmd,
	mvm_rsp_if.source                   rsp,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [mvm_pkg::PADDR_W-1:0] paddr,
	input  logic [31:0]                 pwdata,
	output logic [31:0]                 prdata,
	output logic                        pready
);
	import mvm_pkg::*;

	localparam int RW    = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
	localparam int CW    = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
	localparam int DW    = DATA_WIDTH;
	localparam int ACC_W = 2 * DW + CW;
	localparam logic signed [DW-1:0] DHI = {1'b0, {(DW - 1){1'b1}}};
	localparam logic signed [DW-1:0] DLO = {1'b1, {(DW - 1){1'b0}}};

	cfg_t                 cfg;
	logic                 accept;
	logic                 start;
	logic                 adv;
	logic [RW-1:0]        rows_last;
	logic [CW-1:0]        cols_last;
	tag_t                 tag_s0;

	// Run sequencer
	logic                 running_q;
	logic [RW-1:0]        i_q;
	logic [CW-1:0]        j_q;
	logic [RW-1:0]        rlast_q;
	logic [CW-1:0]        clast_q;

	// Datapath
	logic signed [DW-1:0]   a_rd;
	logic signed [DW-1:0]   x_rd;
	logic signed [DW-1:0]   y_rd;
	logic                   v_s1;
	tag_t                   tag_s1;
	logic                   v_s2;
	logic signed [2*DW-1:0] prod_s2;
	logic signed [DW-1:0]   y_s2;
	tag_t                   tag_s2;
	logic                   v_s3;
	logic signed [DW-1:0]   y_s3;
	tag_t                   tag_s3;
	logic signed [ACC_W-1:0] acc_q;
	logic signed [ACC_W-1:0] acc_next;

	logic                 out_vld;
	logic signed [DW-1:0] out_value;
	res_info_t            out_info;

	mvm_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	assign accept    = cmd.valid && cmd.ready;
	assign start     = accept && (cmd.op == OP_START);
	assign cmd.ready = !running_q;
	assign adv       = !out_vld || rsp.ready;

	// Sizes clamped to 1..MAX, kept as last index
	always_comb begin
		if (cfg.rows == 7'd0) begin
			rows_last = '0;
		end else if (int'(cfg.rows) > MAX_ROWS) begin
			rows_last = RW'(MAX_ROWS - 1);
		end else begin
			rows_last = RW'(cfg.rows - 7'd1);
		end
		if (cfg.cols == 7'd0) begin
			cols_last = '0;
		end else if (int'(cfg.cols) > MAX_COLS) begin
			cols_last = CW'(MAX_COLS - 1);
		end else begin
			cols_last = CW'(cfg.cols - 7'd1);
		end
	end

	// Row/column walk, one element per advancing cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			running_q <= 1'b0;
			i_q       <= '0;
			j_q       <= '0;
			rlast_q   <= RW'(MAX_ROWS - 1);
			clast_q   <= CW'(MAX_COLS - 1);
		end else if (start) begin
			running_q <= 1'b1;
			i_q       <= '0;
			j_q       <= '0;
			rlast_q   <= rows_last;
			clast_q   <= cols_last;
		end else if (running_q && adv) begin
			if (j_q == clast_q) begin
				j_q <= '0;
				if (i_q == rlast_q) begin
					running_q <= 1'b0;
				end else begin
					i_q <= i_q + 1'b1;
				end
			end else begin
				j_q <= j_q + 1'b1;
			end
		end
	end

	always_comb begin
		tag_s0.row       = IDX_W'(i_q);
		tag_s0.first_col = (j_q == '0);
		tag_s0.last_col  = (j_q == clast_q);
		tag_s0.last_row  = (i_q == rlast_q);
	end

	mvm_store #(
		.MAX_ROWS   (MAX_ROWS),
		.MAX_COLS   (MAX_COLS),
		.DATA_WIDTH (DATA_WIDTH)
	) u_store (
		.clk     (clk),
		.wr_en   (accept),
		.wr_op   (cmd.op),
		.wr_row  (cmd.row_index),
		.wr_col  (cmd.col_index),
		.wr_data (cmd.element_value),
		.rd_en   (adv),
		.rd_row  (i_q),
		.rd_col  (j_q),
		.a_rd    (a_rd),
		.x_rd    (x_rd),
		.y_rd    (y_rd)
	);

	// Accumulate; a new row restarts from its first product
	always_comb begin
		acc_next = (tag_s2.first_col ? '0 : acc_q) + ACC_W'(prod_s2);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (adv) begin
			v_s1 <= running_q;
			v_s2 <= v_s1;
			v_s3 <= v_s2 && tag_s2.last_col;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			tag_s1  <= tag_s0;
			prod_s2 <= a_rd * x_rd;
			y_s2    <= y_rd;
			tag_s2  <= tag_s1;
			y_s3    <= y_s2;
			tag_s3  <= tag_s2;
			if (v_s2) begin
				acc_q <= acc_next;
			end
		end
	end

	mvm_scale #(
		.DATA_WIDTH (DATA_WIDTH),
		.ACC_W      (ACC_W)
	) u_scale (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (adv),
		.cfg    (cfg),
		.v_in   (v_s3),
		.dot    (acc_q),
		.y_in   (y_s3),
		.tag_in (tag_s3),
		.vld    (out_vld),
		.value  (out_value),
		.info   (out_info)
	);

	assign rsp.valid        = out_vld;
	assign rsp.result_value = out_value;
	assign rsp.result_row   = out_info.row;
	assign rsp.last_of_run  = out_info.last_of_run;
	assign rsp.saturated    = out_info.saturated;

	// A taken start always launches a run
	a_start_runs: assert property (@(posedge clk) disable iff (!arst_n)
		start |=> running_q)
		else $error("start item did not launch a run");

	// Walk counters stay inside the active region
	a_walk_bounds: assert property (@(posedge clk) disable iff (!arst_n)
		running_q |-> (i_q <= rlast_q) && (j_q <= clast_q))
		else $error("row/column walk out of range");

	// Saturation flag only on a clipped limit value
	a_sat_value: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && rsp.saturated) |->
			(rsp.result_value == DHI) || (rsp.result_value == DLO))
		else $error("saturated flag on an unclipped value");

	// The final result of a run carries the last active row
	a_last_row: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && rsp.last_of_run) |-> (rsp.result_row == IDX_W'(rlast_q)))
		else $error("last_of_run on the wrong row");

endmodule
